// ===== hdl/clc_pkg.sv =====
// clc_pkg: shared types and constants of the complex linear convolution core
// used by complex_linear_convolution_core and clc_checker; no dependencies
`timescale 1ns / 1ps

package clc_pkg;

  localparam int MAX_LEN_DEF     = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 5;
  localparam int FIELD_W    = 16;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int ACC_W      = 40;
  localparam int OUT_IDX_W  = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 88;

  // input payload layout
  localparam int IN_IDX_LSB = 0;
  localparam int IN_RE_LSB  = IN_IDX_LSB + IDX_W;
  localparam int IN_IM_LSB  = IN_RE_LSB + FIELD_W;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_B = 1'b1;

  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_SIZE_ERR = 1'b1;

endpackage

// ===== hdl/complex_linear_convolution_core.sv =====
// A run gives its outputs in order of m, output m summing its a[k]*b[m-k] terms
// through ST_SETUP, ST_RUN, ST_DRAIN and ST_EMIT.
// Throughput: one complex multiply-accumulate per cycle while in ST_RUN, bound by the single read
// port of each sample memory; a load request is taken whenever the core is idle.
// A size-error run gives its single result through ST_EMIT and the output register.
// Reset (synchronous, rst_n low): lengths return to 1, control idles, memories kept
// complex_linear_convolution_core: sample memories, MAC pipeline and sequencer
// depends on clc_pkg
`timescale 1ns / 1ps

module complex_linear_convolution_core #(
  parameter int MAX_LEN     = clc_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = clc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // sample_index, sample_re, sample_im, zero fill
  input  logic [clc_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [clc_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_index, out_re, out_im, zero fill
  output logic [clc_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [0:0]                     out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [clc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clc_pkg::LEN_W-1:0]      cfg_data
);
  import clc_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int EW = 2 * SAMPLE_BITS;
  localparam int OW = OUT_IDX_W;

  // sample memories, {im, re} per entry
  logic [EW-1:0] mem_a [MAX_LEN];
  logic [EW-1:0] mem_b [MAX_LEN];

  state_t state_r, state_nxt;
  logic [LEN_W-1:0] len_a_r, len_b_r;
  logic [OW-1:0]    m_r, m_nxt;
  logic [AW-1:0]    k_r, k_nxt, kend_r, kend_nxt;
  logic             err_r, err_nxt;
  logic             acc_clr, out_load;

  logic [LW-1:0] na, nb;
  logic [OW-1:0] kstart6, kend6, b_idx6, m_last;

  logic           accept, idx_ok;
  op_t            in_op;
  logic [AW-1:0]  wr_idx;
  logic [EW-1:0]  wr_word;

  logic [EW-1:0]  rd_a_r, rd_b_r;
  logic           rd_vld_r, mul_vld_r;
  logic signed [SAMPLE_BITS-1:0] ar, ai, br, bi;
  logic signed [EW-1:0] pp_rr_r, pp_ii_r, pp_ri_r, pp_ir_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;

  logic                 out_tvalid_r, out_status_r, out_last_r;
  logic [OW-1:0]        out_idx_r;
  logic [ACC_W-1:0]     out_re_r, out_im_r;

  // lengths above the store size saturate
  assign na = (len_a_r > LEN_W'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(len_a_r);
  assign nb = (len_b_r > LEN_W'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(len_b_r);

  // term range of output m: k from max(0, m-nb+1) to min(m, na-1)
  assign kstart6 = (m_r >= OW'(nb)) ? (m_r - OW'(nb) + OW'(1)) : '0;
  assign kend6   = (m_r < (OW'(na) - OW'(1))) ? m_r : (OW'(na) - OW'(1));
  assign b_idx6  = m_r - OW'(k_r);
  assign m_last  = OW'(na) + OW'(nb) - OW'(2);

  assign in_tready = (state_r == ST_IDLE);
  assign in_op   = op_t'(in_tuser);
  assign accept  = in_tvalid && in_tready;
  assign idx_ok  = ({1'b0, in_tdata[IN_IDX_LSB +: IDX_W]} < (IDX_W + 1)'(MAX_LEN));
  assign wr_idx  = in_tdata[IN_IDX_LSB +: AW];
  assign wr_word = {SAMPLE_BITS'(in_tdata[IN_IM_LSB +: FIELD_W]),
                    SAMPLE_BITS'(in_tdata[IN_RE_LSB +: FIELD_W])};

  always_ff @(posedge clk) begin
    if (accept && idx_ok && (in_op == OP_LOAD_A)) begin
      mem_a[wr_idx] <= wr_word;
    end
    if (accept && idx_ok && (in_op == OP_LOAD_B)) begin
      mem_b[wr_idx] <= wr_word;
    end
    if (state_r == ST_RUN) begin
      rd_a_r <= mem_a[k_r];
      rd_b_r <= mem_b[b_idx6[AW-1:0]];
    end
  end

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    k_nxt     = k_r;
    kend_nxt  = kend_r;
    err_nxt   = err_r;
    acc_clr   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_RUN)) begin
          m_nxt     = '0;
          err_nxt   = (na == '0) || (nb == '0);
          acc_clr   = 1'b1;
          state_nxt = err_nxt ? ST_EMIT : ST_SETUP;
        end
      end
      ST_SETUP: begin
        k_nxt     = kstart6[AW-1:0];
        kend_nxt  = kend6[AW-1:0];
        acc_clr   = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        k_nxt = k_r + AW'(1);
        if (k_r == kend_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last term to leave the multiplier and land in the sums
        if (!rd_vld_r && !mul_vld_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load = 1'b1;
          if (err_r || (m_r == m_last)) begin
            state_nxt = ST_IDLE;
          end else begin
            m_nxt     = m_r + OW'(1);
            state_nxt = ST_SETUP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      m_r       <= '0;
      k_r       <= '0;
      kend_r    <= '0;
      err_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      len_a_r   <= LEN_W'(1);
      len_b_r   <= LEN_W'(1);
    end else begin
      state_r   <= state_nxt;
      m_r       <= m_nxt;
      k_r       <= k_nxt;
      kend_r    <= kend_nxt;
      err_r     <= err_nxt;
      rd_vld_r  <= (state_r == ST_RUN);
      mul_vld_r <= rd_vld_r;
      if (cfg_we) begin
        case (cfg_index)
          REG_LENGTH_A: len_a_r <= cfg_data;
          REG_LENGTH_B: len_b_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign ar = rd_a_r[SAMPLE_BITS-1:0];
  assign ai = rd_a_r[EW-1:SAMPLE_BITS];
  assign br = rd_b_r[SAMPLE_BITS-1:0];
  assign bi = rd_b_r[EW-1:SAMPLE_BITS];

  always_ff @(posedge clk) begin
    pp_rr_r <= ar * br;
    pp_ii_r <= ai * bi;
    pp_ri_r <= ar * bi;
    pp_ir_r <= ai * br;
    if (acc_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (mul_vld_r) begin
      acc_re_r <= acc_re_r + ACC_W'(pp_rr_r) - ACC_W'(pp_ii_r);
      acc_im_r <= acc_im_r + ACC_W'(pp_ri_r) + ACC_W'(pp_ir_r);
    end
  end

  // output register parts the result side from the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= err_r ? STAT_SIZE_ERR : STAT_OK;
      out_idx_r    <= m_r;
      out_re_r     <= acc_re_r;
      out_im_r     <= acc_im_r;
      out_last_r   <= err_r || (m_r == m_last);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_DATA_W - OW - 2 * ACC_W)'(0), out_im_r, out_re_r, out_idx_r};

endmodule

// ===== hdl/clc_checker.sv =====
// clc_checker: port-level assertions for complex_linear_convolution_core
// depends on clc_pkg; bound to complex_linear_convolution_core at the end of this file
`timescale 1ns / 1ps

module clc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [clc_pkg::OP_W-1:0]       in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [clc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                     out_tuser,
  input logic                           out_tlast
);
  import clc_pkg::*;

  // a size error is a lone, zero result
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == STAT_SIZE_ERR) |-> out_tlast && (out_tdata == '0))
    else $error("size error result not marked last or not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // while a run is unfinished no new request is taken
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request taken during a run");

  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_RUN) |=> !in_tready)
    else $error("ready right after a run request");

endmodule

bind complex_linear_convolution_core clc_checker u_clc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/tb.sv =====
// tb: self-checking bench for complex_linear_convolution_core, sample loads and
// convolution runs checked result by result against an in-bench predictor
// depends on clc_pkg and complex_linear_convolution_core
`timescale 1ns / 1ps

module tb;
  import clc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int OUT_IDX_LSB = 0;
  localparam int OUT_RE_LSB  = OUT_IDX_LSB + OUT_IDX_W;
  localparam int OUT_IM_LSB  = OUT_RE_LSB + ACC_W;
  localparam int N_DIRECTED  = 20;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 5;

  typedef struct packed {
    logic                 status;
    logic [OUT_IDX_W-1:0] index;
    logic [ACC_W-1:0]     re;
    logic [ACC_W-1:0]     im;
    logic                 last;
  } conv_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_LENGTHS
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [OP_W-1:0]      op;
    logic [IDX_W-1:0]     idx;
    logic [FIELD_W-1:0]   re;
    logic [FIELD_W-1:0]   im;
    logic [LEN_W-1:0]     len_a;
    logic [LEN_W-1:0]     len_b;
    logic                 typed;
    conv_result_t         want;
  } dir_row_t;

  localparam conv_result_t NO_RESULT = '0;
  localparam conv_result_t SIZE_ERR_RESULT = '{STAT_SIZE_ERR, 6'd0, 40'd0, 40'd0, 1'b1};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [LEN_W-1:0]      cfg_data;

  // predictor copy of the sample stores and lengths
  logic signed [FIELD_W-1:0] a_re [MAX_LEN_DEF];
  logic signed [FIELD_W-1:0] a_im [MAX_LEN_DEF];
  logic signed [FIELD_W-1:0] b_re [MAX_LEN_DEF];
  logic signed [FIELD_W-1:0] b_im [MAX_LEN_DEF];
  logic [LEN_W-1:0]          len_a;
  logic [LEN_W-1:0]          len_b;

  conv_result_t pending_results [$];
  dir_row_t     dir_tab [N_DIRECTED];

  bit idle_on;
  int pending_gap;
  int n_requests;
  int n_runs;
  int n_results;
  int n_errors;

  complex_linear_convolution_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic convolve_stores();
    int na;
    int nb;
    int n;
    longint acc_re;
    longint acc_im;
    conv_result_t r;
    na = (len_a > MAX_LEN_DEF) ? MAX_LEN_DEF : len_a;
    nb = (len_b > MAX_LEN_DEF) ? MAX_LEN_DEF : len_b;
    if (na == 0 || nb == 0) begin
      pending_results.push_back(SIZE_ERR_RESULT);
      return;
    end
    for (int m = 0; m < na + nb - 1; m++) begin
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < na && k <= m; k++) begin
        n = m - k;
        if (n < nb) begin
          acc_re += longint'(a_re[k]) * longint'(b_re[n])
                  - longint'(a_im[k]) * longint'(b_im[n]);
          acc_im += longint'(a_re[k]) * longint'(b_im[n])
                  + longint'(a_im[k]) * longint'(b_re[n]);
        end
      end
      r.status = STAT_OK;
      r.index  = m[OUT_IDX_W-1:0];
      r.re     = acc_re[ACC_W-1:0];
      r.im     = acc_im[ACC_W-1:0];
      r.last   = (m == na + nb - 2);
      pending_results.push_back(r);
    end
  endtask

  task automatic predict_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                 input logic [FIELD_W-1:0] re, input logic [FIELD_W-1:0] im);
    case (op)
      OP_LOAD_A: begin
        a_re[idx] = re;
        a_im[idx] = im;
      end
      OP_LOAD_B: begin
        b_re[idx] = re;
        b_im[idx] = im;
      end
      OP_RUN: convolve_stores();
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [FIELD_W-1:0] re, input logic [FIELD_W-1:0] im,
                              input logic typed, input conv_result_t want);
    logic [IN_DATA_W-1:0] data;
    data = '0;
    data[IN_IDX_LSB +: IDX_W] = idx;
    data[IN_RE_LSB +: FIELD_W] = re;
    data[IN_IM_LSB +: FIELD_W] = im;
    repeat (pending_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_requests++;
    if (op == OP_RUN) n_runs++;
    if (typed) pending_results.push_back(want);
    else predict_request(op, idx, re, im);
    // valid stays up only when the next request follows at once
    pending_gap = idle_on ? $urandom_range(0, 9) : 0;
    if (pending_gap != 0) in_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // loads give no result, so leave room for anything still in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic set_lengths(input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LENGTH_A;
    cfg_data  <= la;
    @(posedge clk);
    cfg_index <= REG_LENGTH_B;
    cfg_data  <= lb;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_a = la;
    len_b = lb;
  endtask

  function automatic logic [FIELD_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // result side: random stalls, checks every accepted result in order
  initial begin : result_side
    int stall;
    conv_result_t got;
    conv_result_t want;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.status = out_tuser[0];
      got.index  = out_tdata[OUT_IDX_LSB +: OUT_IDX_W];
      got.re     = out_tdata[OUT_RE_LSB +: ACC_W];
      got.im     = out_tdata[OUT_IM_LSB +: ACC_W];
      got.last   = out_tlast;
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected: status %0d index %0d re %0d im %0d last %0d",
                 $time, got.status, got.index, $signed(got.re), $signed(got.im), got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          n_errors++;
          $display("%0t: mismatch expected status %0d index %0d re %0d im %0d last %0d",
                   $time, want.status, want.index, $signed(want.re), $signed(want.im),
                   want.last);
          $display("%0t:          actual   status %0d index %0d re %0d im %0d last %0d",
                   $time, got.status, got.index, $signed(got.re), $signed(got.im), got.last);
        end
      end
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] la;
    logic [LEN_W-1:0] lb;
    dir_row_t row;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    idle_on = 1'b1;
    pending_gap = 0;
    n_requests = 0;
    n_runs = 0;
    n_results = 0;
    n_errors = 0;
    len_a = 6'd1;
    len_b = 6'd1;
    for (int i = 0; i < MAX_LEN_DEF; i++) begin
      a_re[i] = '0;
      a_im[i] = '0;
      b_re[i] = '0;
      b_im[i] = '0;
    end

    // both samples at most negative: re cancels, im is 2^31
    dir_tab[0]  = '{ROW_ITEM, OP_LOAD_A, 5'd0, 16'h8000, 16'h8000, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[1]  = '{ROW_ITEM, OP_LOAD_B, 5'd0, 16'h8000, 16'h8000, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[2]  = '{ROW_ITEM, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b1,
                    '{STAT_OK, 6'd0, 40'd0, 40'd2147483648, 1'b1}};
    dir_tab[3]  = '{ROW_ITEM, OP_LOAD_B, 5'd0, 16'h7fff, 16'h7fff, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[4]  = '{ROW_ITEM, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[5]  = '{ROW_ITEM, OP_LOAD_A, 5'd1, 16'h7fff, 16'h8000, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[6]  = '{ROW_ITEM, OP_LOAD_B, 5'd1, 16'hffff, 16'h7fff, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[7]  = '{ROW_LENGTHS, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd2, 6'd2, 1'b0, NO_RESULT};
    dir_tab[8]  = '{ROW_ITEM, OP_RUN, 5'd31, 16'hffff, 16'hffff, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[9]  = '{ROW_ITEM, OP_LOAD_A, 5'd31, 16'h7fff, 16'h7fff, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[10] = '{ROW_ITEM, OP_LOAD_B, 5'd31, 16'h8000, 16'h0000, 6'd0, 6'd0, 1'b0, NO_RESULT};
    // unused op code: dropped without a result
    dir_tab[11] = '{ROW_ITEM, OP_UNUSED, 5'd31, 16'hffff, 16'hffff, 6'd0, 6'd0, 1'b0,
                    NO_RESULT};
    dir_tab[12] = '{ROW_LENGTHS, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd0, 6'd2, 1'b0, NO_RESULT};
    dir_tab[13] = '{ROW_ITEM, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b1,
                    SIZE_ERR_RESULT};
    dir_tab[14] = '{ROW_LENGTHS, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd2, 6'd0, 1'b0, NO_RESULT};
    dir_tab[15] = '{ROW_ITEM, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b1,
                    SIZE_ERR_RESULT};
    dir_tab[16] = '{ROW_LENGTHS, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b0, NO_RESULT};
    dir_tab[17] = '{ROW_ITEM, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b1,
                    SIZE_ERR_RESULT};
    dir_tab[18] = '{ROW_LENGTHS, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd1, 6'd2, 1'b0, NO_RESULT};
    dir_tab[19] = '{ROW_ITEM, OP_RUN, 5'd0, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b0, NO_RESULT};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = dir_tab[i];
      if (row.kind == ROW_LENGTHS) begin
        wait_idle();
        set_lengths(row.len_a, row.len_b);
      end else begin
        send_request(row.op, row.idx, row.re, row.im, row.typed, row.want);
      end
    end

    // fill both stores so any length, saturated ones too, reads written entries
    idle_on = 1'b0;
    for (int i = 0; i < MAX_LEN_DEF; i++) begin
      send_request(OP_LOAD_A, i[IDX_W-1:0], draw_sample(), draw_sample(), 1'b0, NO_RESULT);
      send_request(OP_LOAD_B, i[IDX_W-1:0], draw_sample(), draw_sample(), 1'b0, NO_RESULT);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin la = 6'd32; lb = 6'd32; end
        1: begin la = 6'd63; lb = 6'd33; end
        2: begin la = 6'd1;  lb = 6'd32; end
        3: begin la = 6'd0;  lb = 6'd7;  end
        4: begin la = 6'd5;  lb = 6'd0;  end
        default: begin
          la = LEN_W'($urandom_range(1, 8));
          lb = LEN_W'($urandom_range(1, 8));
        end
      endcase
      wait_idle();
      set_lengths(la, lb);
      idle_on = p[0] ? 1'b0 : 1'b1;
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: op = OP_LOAD_A;
          3, 4, 5: op = OP_LOAD_B;
          6, 7, 8: op = OP_RUN;
          default: op = OP_UNUSED;
        endcase
        send_request(op, IDX_W'($urandom_range(0, 31)), draw_sample(), draw_sample(), 1'b0,
                     NO_RESULT);
      end
    end

    idle_on = 1'b1;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests with %0d runs, %0d results checked", n_requests, n_runs,
             n_results);
    $display("lengths from zero through saturation, extreme samples, unused op code");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
